// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// Sampled on clk_i; the first form is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/scf_pkg.sv =====
// Package for the sphere contact force and stiffness unit.
// Field widths, datapath widths and register indexes; no dependencies.
`default_nettype none

package scf_pkg;

  localparam int unsigned NodeW    = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned OutW     = 48;
  localparam int unsigned NumVals  = 9;
  localparam int unsigned InDataW  = NodeW + 3 * CoordW;
  localparam int unsigned OutDataW = NodeW + NumVals * OutW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RadW     = 31;
  localparam int unsigned KW       = 32;
  localparam int unsigned MaxNodes = 65536;

  localparam int unsigned DiffW  = 33;
  localparam int unsigned MagW   = 32;
  localparam int unsigned SqW    = 64;
  localparam int unsigned SumW   = 66;
  localparam int unsigned RootW  = 33;
  localparam int unsigned RemW   = 35;
  localparam int unsigned DrW    = 64;
  localparam int unsigned D2W    = 66;
  localparam int unsigned D3W    = 99;
  localparam int unsigned KrdW   = 65;
  localparam int unsigned KpW    = 96;
  localparam int unsigned FnumW  = 97;
  localparam int unsigned TnumW  = 81;
  localparam int unsigned SnumW  = 112;
  localparam int unsigned QuoBits = 52;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCentreX   = 3'd0,
    CfgCentreY   = 3'd1,
    CfgCentreZ   = 3'd2,
    CfgRadius    = 3'd3,
    CfgStiffComp = 3'd4,
    CfgStiffTens = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/scf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Gives QuoW low quotient bits plus a flag for quotients >= 2^QuoW; no package use.
`default_nettype none

module scf_div #(
  parameter int unsigned NumW = 97,
  parameter int unsigned DenW = 64,
  parameter int unsigned QuoW = 52
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o,
  output logic            ovf_o
);

  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [RemW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic            ovf_q [QuoW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= RemW'(num_i) >= (RemW'(den_i) << QuoW);
    end
  end

  for (genvar j = 1; j <= QuoW; j++) begin : g_stage
    logic [RemW-1:0] trial;
    logic            take;

    assign trial = RemW'(den_q[j-1]) << (QuoW - j);
    assign take  = rem_q[j-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_q[j-1][QuoW-2:0], take};
        ovf_q[j] <= ovf_q[j-1];
      end
    end

    if (j < QuoW) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? rem_q[j-1] - trial : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign ovf_o = ovf_q[QuoW];

endmodule

`default_nettype wire

// ===== rtl/sphere_contact_force_stiffness_unit.sv =====
// Sphere contact force and stiffness unit, top level.
// Accepts one item per cycle while the output is not stalled.
// Depth is set by the 33-stage square root and the 53-stage dividers (an input register, then one bit per stage).
// A result not taken stalls the whole pipe; dropped items leave a bubble.
// Reset (async, active low) clears valid bits and the configuration registers.
`default_nettype none

module sphere_contact_force_stiffness_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_index, pos_x, pos_y, pos_z
  input  logic [scf_pkg::InDataW-1:0]   s_axis_tdata,
  // node_active
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // node_out, force_x, force_y, force_z, k_xx, k_yy, k_zz, k_xy, k_xz, k_yz
  output logic [scf_pkg::OutDataW-1:0]  m_axis_tdata,
  // degenerate
  output logic                          m_axis_tuser
);

  import scf_pkg::*;

  localparam int unsigned StB     = 1;
  localparam int unsigned StSq0   = 4;
  localparam int unsigned StE     = StSq0 + RootW;
  localparam int unsigned StH     = StE + 3;
  localparam int unsigned NumSide = StH + QuoBits + 2;

  typedef struct packed {
    logic             vld;
    logic [NodeW-1:0] node;
    logic [2:0]       neg;
    logic             rdneg;
    logic             degen;
  } side_t;

  typedef logic [2:0][MagW-1:0] mag3_t;

  logic adv;

  // configuration registers
  logic [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [RadW-1:0]   radius_q;
  logic [KW-1:0]     kc_q, kt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      radius_q <= '0;
      kc_q     <= '0;
      kt_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCentreX:   cx_q     <= cfg_data_i;
        CfgCentreY:   cy_q     <= cfg_data_i;
        CfgCentreZ:   cz_q     <= cfg_data_i;
        CfgRadius:    radius_q <= cfg_data_i[RadW-1:0];
        CfgStiffComp: kc_q     <= cfg_data_i;
        CfgStiffTens: kt_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sideband pipeline
  side_t side_d [NumSide];
  side_t side_q [NumSide];

  logic [NodeW-1:0]             in_node;
  logic [2:0][CoordW-1:0]       in_pos;
  logic [2:0][CoordW-1:0]       cen;
  logic signed [DiffW-1:0]      a_diff_q [3];
  mag3_t                        b_mag_q;
  logic [2:0]                   b_neg;
  logic [RootW-1:0]             e_d;
  logic                         e_rdneg;

  assign in_node   = s_axis_tdata[NodeW-1:0];
  assign in_pos[0] = s_axis_tdata[NodeW +: CoordW];
  assign in_pos[1] = s_axis_tdata[NodeW + CoordW +: CoordW];
  assign in_pos[2] = s_axis_tdata[NodeW + 2 * CoordW +: CoordW];
  assign cen       = {cz_q, cy_q, cx_q};

  for (genvar i = 0; i < 3; i++) begin : g_neg
    assign b_neg[i] = a_diff_q[i][DiffW-1];
  end

  always_comb begin
    side_d[0].vld   = s_axis_tvalid & s_axis_tuser & (radius_q != '0) &
                      (32'(in_node) < MaxNodes);
    side_d[0].node  = in_node;
    side_d[0].neg   = '0;
    side_d[0].rdneg = 1'b0;
    side_d[0].degen = 1'b0;
    for (int j = 1; j < NumSide; j++) begin
      side_d[j] = side_q[j-1];
    end
    side_d[StB].neg   = b_neg;
    side_d[StE].rdneg = e_rdneg;
    side_d[StE].degen = (e_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumSide; j++) begin
        side_q[j] <= '0;
      end
    end else if (adv) begin
      for (int j = 0; j < NumSide; j++) begin
        side_q[j] <= side_d[j];
      end
    end
  end

  // A: offsets from the centre, B: magnitudes, C: squares, D: sum
  logic [2:0][SqW-1:0] c_sq_q;
  mag3_t               c_mag_q, d_mag_q;
  logic [SumW-1:0]     d_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_diff_q[i] <= DiffW'(signed'(in_pos[i])) - DiffW'(signed'(cen[i]));
        b_mag_q[i]  <= a_diff_q[i][DiffW-1] ? MagW'(-a_diff_q[i]) : MagW'(a_diff_q[i]);
        c_sq_q[i]   <= SqW'(b_mag_q[i]) * SqW'(b_mag_q[i]);
      end
      c_mag_q <= b_mag_q;
      d_sum_q <= SumW'(c_sq_q[0]) + SumW'(c_sq_q[1]) + SumW'(c_sq_q[2]);
      d_mag_q <= c_mag_q;
    end
  end

  // square root, one result bit per stage
  logic [RemW-1:0]  sq_rem_q  [RootW];
  logic [RootW-1:0] sq_root_q [RootW];
  logic [SumW-1:0]  sq_x_q    [RootW-1];
  mag3_t            sq_mag_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SumW-1:0]  x_in;
    mag3_t            mag_in;
    logic [RemW+1:0]  r2, tr;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = d_sum_q;
      assign mag_in  = d_mag_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign mag_in  = sq_mag_q[k-1];
    end

    assign r2  = {rem_in, x_in[SumW-1 -: 2]};
    assign tr  = (RemW + 2)'({root_in, 2'b01});
    assign fit = r2 >= tr;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k]  <= fit ? RemW'(r2 - tr) : RemW'(r2);
        sq_root_q[k] <= {root_in[RootW-2:0], fit};
        sq_mag_q[k]  <= mag_in;
      end
    end

    if (k < RootW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sq_x_q[k] <= x_in << 2;
        end
      end
    end
  end

  // E: stiffness pick, d*R, d*d and coordinate products (xx yy zz xy xz yz)
  logic [RootW-1:0]    e_rdmag;
  logic [RootW-1:0]    e_rdmag_q, e_d_q;
  logic [KW-1:0]       e_k_q;
  logic [DrW-1:0]      e_dr_q;
  logic [D2W-1:0]      e_d2_q;
  logic [5:0][SqW-1:0] e_p_q;
  mag3_t               e_mag, e_mag_q;

  assign e_d     = sq_root_q[RootW-1];
  assign e_mag   = sq_mag_q[RootW-1];
  assign e_rdneg = e_d > RootW'(radius_q);
  assign e_rdmag = e_rdneg ? e_d - RootW'(radius_q) : RootW'(radius_q) - e_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_rdmag_q <= e_rdmag;
      e_d_q     <= e_d;
      e_k_q     <= e_rdneg ? kt_q : kc_q;
      e_dr_q    <= DrW'(e_d) * DrW'(radius_q);
      e_d2_q    <= D2W'(e_d) * D2W'(e_d);
      e_p_q[0]  <= SqW'(e_mag[0]) * SqW'(e_mag[0]);
      e_p_q[1]  <= SqW'(e_mag[1]) * SqW'(e_mag[1]);
      e_p_q[2]  <= SqW'(e_mag[2]) * SqW'(e_mag[2]);
      e_p_q[3]  <= SqW'(e_mag[0]) * SqW'(e_mag[1]);
      e_p_q[4]  <= SqW'(e_mag[0]) * SqW'(e_mag[2]);
      e_p_q[5]  <= SqW'(e_mag[1]) * SqW'(e_mag[2]);
      e_mag_q   <= e_mag;
    end
  end

  // F: partial products of k*(R-d), d^3 and k*p
  logic [KrdW-1:0]     f_krd_q;
  logic [64:0]         f_d3l_q;
  logic [66:0]         f_d3h_q;
  logic [5:0][63:0]    f_kpl_q, f_kph_q;
  logic [DrW-1:0]      f_dr_q;
  mag3_t               f_mag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_krd_q <= KrdW'(e_k_q) * KrdW'(e_rdmag_q);
      f_d3l_q <= 65'(e_d2_q[31:0]) * 65'(e_d_q);
      f_d3h_q <= 67'(e_d2_q[D2W-1:32]) * 67'(e_d_q);
      for (int i = 0; i < 6; i++) begin
        f_kpl_q[i] <= 64'(e_k_q) * 64'(e_p_q[i][31:0]);
        f_kph_q[i] <= 64'(e_k_q) * 64'(e_p_q[i][63:32]);
      end
      f_dr_q  <= e_dr_q;
      f_mag_q <= e_mag_q;
    end
  end

  // G: d^3 and k*p assembled, force partial products
  logic [D3W-1:0]      g_d3_q;
  logic [5:0][KpW-1:0] g_kp_q;
  logic [2:0][63:0]    g_fl_q;
  logic [2:0][64:0]    g_fh_q;
  logic [DrW-1:0]      g_dr_q;
  logic [KrdW-1:0]     g_krd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_d3_q <= (D3W'(f_d3h_q) << 32) + D3W'(f_d3l_q);
      for (int i = 0; i < 6; i++) begin
        g_kp_q[i] <= (KpW'(f_kph_q[i]) << 32) + KpW'(f_kpl_q[i]);
      end
      for (int i = 0; i < 3; i++) begin
        g_fl_q[i] <= 64'(f_krd_q[31:0]) * 64'(f_mag_q[i]);
        g_fh_q[i] <= 65'(f_krd_q[KrdW-1:32]) * 65'(f_mag_q[i]);
      end
      g_dr_q  <= f_dr_q;
      g_krd_q <= f_krd_q;
    end
  end

  // H: dividend and divisor registers
  logic [2:0][FnumW-1:0] h_fnum_q;
  logic [TnumW-1:0]      h_tnum_q;
  logic [5:0][SnumW-1:0] h_snum_q;
  logic [DrW-1:0]        h_dr_q;
  logic [D3W-1:0]        h_d3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h_fnum_q[i] <= (FnumW'(g_fh_q[i]) << 32) + FnumW'(g_fl_q[i]);
      end
      for (int i = 0; i < 6; i++) begin
        h_snum_q[i] <= SnumW'(g_kp_q[i]) << 16;
      end
      h_tnum_q <= TnumW'(g_krd_q) << 16;
      h_dr_q   <= g_dr_q;
      h_d3_q   <= g_d3_q;
    end
  end

  // dividers
  logic [2:0][QuoBits-1:0] fq;
  logic [2:0]              fovf;
  logic [5:0][QuoBits-1:0] sq;
  logic [5:0]              sovf;
  logic [QuoBits-1:0]      tq;
  logic                    tovf;

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    scf_div #(.NumW(FnumW), .DenW(DrW), .QuoW(QuoBits)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (h_fnum_q[i]),
      .den_i (h_dr_q),
      .quo_o (fq[i]),
      .ovf_o (fovf[i])
    );
  end

  for (genvar i = 0; i < 6; i++) begin : g_sdiv
    scf_div #(.NumW(SnumW), .DenW(D3W), .QuoW(QuoBits)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (h_snum_q[i]),
      .den_i (h_d3_q),
      .quo_o (sq[i]),
      .ovf_o (sovf[i])
    );
  end

  scf_div #(.NumW(TnumW), .DenW(DrW), .QuoW(QuoBits)) u_tdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (h_tnum_q),
    .den_i (h_dr_q),
    .quo_o (tq),
    .ovf_o (tovf)
  );

  // sign, diagonal sum and saturation
  localparam logic [OutW-1:0]        PosLim = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0]        NegLim = {1'b1, {(OutW-1){1'b0}}};
  localparam logic signed [QuoBits+1:0] SumMax = (QuoBits+2)'(PosLim);
  localparam logic signed [QuoBits+1:0] SumMin = -(QuoBits+2)'(NegLim);

  function automatic logic [OutW-1:0] sat_mag(logic neg, logic ovf, logic [QuoBits-1:0] q);
    logic [QuoBits-1:0] lim;
    logic [OutW-1:0]    m;
    lim = neg ? QuoBits'(NegLim) : QuoBits'(PosLim);
    m   = (ovf || q > lim) ? OutW'(lim) : OutW'(q);
    return neg ? -m : m;
  endfunction

  side_t                     last;
  logic [NumVals-1:0][OutW-1:0] val_d;

  assign last = side_q[NumSide-1];

  always_comb begin
    logic signed [QuoBits+1:0] v;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      val_d[i] = sat_mag(last.rdneg ^ last.neg[i], fovf[i], fq[i]);
      // d beyond the radius makes the (R-d) term negative
      if (last.rdneg) begin
        v = signed'((QuoBits+2)'(sq[i])) + signed'((QuoBits+2)'(tq));
      end else begin
        v = signed'((QuoBits+2)'(sq[i])) - signed'((QuoBits+2)'(tq));
      end
      if (tovf) begin
        val_d[3+i] = last.rdneg ? PosLim : NegLim;
      end else if (sovf[i] || v > SumMax) begin
        val_d[3+i] = PosLim;
      end else if (v < SumMin) begin
        val_d[3+i] = NegLim;
      end else begin
        val_d[3+i] = v[OutW-1:0];
      end
    end
    val_d[6] = sat_mag(last.neg[0] ^ last.neg[1], sovf[3], sq[3]);
    val_d[7] = sat_mag(last.neg[0] ^ last.neg[2], sovf[4], sq[4]);
    val_d[8] = sat_mag(last.neg[1] ^ last.neg[2], sovf[5], sq[5]);
    if (last.degen) begin
      val_d = '0;
    end
  end

  // output register
  logic                         out_vld_q;
  logic [NodeW-1:0]             out_node_q;
  logic [NumVals-1:0][OutW-1:0] out_val_q;
  logic                         out_degen_q;

  assign adv = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_node_q  <= last.node;
      out_val_q   <= val_d;
      out_degen_q <= last.degen;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_val_q, out_node_q};
  assign m_axis_tuser  = out_degen_q;

endmodule

`default_nettype wire

// ===== rtl/scf_checker.sv =====
// Port-level checks for the sphere contact force and stiffness unit.
// Uses scf_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module scf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [scf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  import scf_pkg::*;

  // a held result blocks the input side
  `SCF_ASSERT(a_stall_backs_up, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")
  `SCF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")
  `SCF_ASSERT(a_degen_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OutDataW-1:NodeW] == '0, "degenerate item with nonzero values")
  `SCF_ASSERT_RST(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind sphere_contact_force_stiffness_unit scf_checker u_scf_checker (.*);

`default_nettype wire

// ===== test/scf_checker.sv =====
// Checker for the sphere contact force and stiffness unit: watches the config port
// and both streams, predicts each result and compares it field by field.
// Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_tb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [scf_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [scf_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          m_axis_tuser,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            seen_o,
  output int                            degen_o
);
  import scf_pkg::*;

  typedef struct packed {
    logic          degen;
    logic [9*48-1:0] vals;
    logic [15:0]   node;
  } contact_res_t;

  logic signed [31:0] cx, cy, cz;
  logic [30:0] rad;
  logic [31:0] kc, kt;
  contact_res_t expect_q[$];

  function automatic logic [47:0] clamp48(input logic signed [129:0] v);
    if (v > 130'sh7FFFFFFFFFFF) return 48'h7FFFFFFFFFFF;
    if (v < -130'sh800000000000) return 48'h800000000000;
    return v[47:0];
  endfunction

  // Truncating signed quotient of exact integer operands.
  function automatic logic signed [129:0] sdiv(input logic signed [129:0] n,
                                                input logic [129:0] d);
    logic [129:0] m;
    m = (n < 0) ? -n : n;
    m = m / d;
    return (n < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic contact_res_t predict_contact(input logic [InDataW-1:0] dat);
    contact_res_t r;
    logic signed [33:0] dv[3];
    logic [129:0] sum, d, root, k, dr, d3;
    logic signed [129:0] rd, t, s;
    int pa[3], pb[3];
    pa = '{0, 0, 1}; pb = '{1, 2, 2};
    r = '0;
    r.node = dat[15:0];
    dv[0] = $signed(dat[47:16]) - cx;
    dv[1] = $signed(dat[79:48]) - cy;
    dv[2] = $signed(dat[111:80]) - cz;
    sum = 0;
    for (int i = 0; i < 3; i++)
      sum += 130'($signed(dv[i])) * 130'($signed(dv[i]));
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      d = root | (130'd1 << b);
      if (d * d <= sum) root = d;
    end
    d = root;
    if (d == 0) begin
      r.degen = 1'b1;
      return r;
    end
    k  = (d > rad) ? kt : kc;
    rd = $signed(130'(rad)) - $signed(d);
    dr = d * rad;
    d3 = d * d * d;
    for (int i = 0; i < 3; i++)
      r.vals[i*48 +: 48] = clamp48(sdiv($signed(k) * rd * 130'($signed(dv[i])), dr));
    t = -sdiv(($signed(k) * rd) <<< 16, dr);
    for (int i = 0; i < 3; i++) begin
      s = sdiv(($signed(k) * 130'($signed(dv[i])) * 130'($signed(dv[i]))) <<< 16, d3);
      r.vals[(3+i)*48 +: 48] = clamp48(t + s);
    end
    for (int i = 0; i < 3; i++) begin
      s = sdiv(($signed(k) * 130'($signed(dv[pa[i]])) * 130'($signed(dv[pb[i]])))
               <<< 16, d3);
      r.vals[(6+i)*48 +: 48] = clamp48(s);
    end
    return r;
  endfunction

  string fname[10] = '{"force_x", "force_y", "force_z", "k_xx", "k_yy", "k_zz",
                       "k_xy", "k_xz", "k_yz", "node_out"};

  always @(posedge clk_i or negedge rst_ni) begin
    contact_res_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      cx <= 0; cy <= 0; cz <= 0; rad <= 0; kc <= 0; kt <= 0;
      fail_cnt_o <= 0; seen_o <= 0; degen_o <= 0; pending_o <= 0;
      expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgCentreX:   cx  <= cfg_data_i;
          CfgCentreY:   cy  <= cfg_data_i;
          CfgCentreZ:   cz  <= cfg_data_i;
          CfgRadius:    rad <= cfg_data_i[30:0];
          CfgStiffComp: kc  <= cfg_data_i;
          CfgStiffTens: kt  <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser && rad != 0)
        expect_q.push_back(predict_contact(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        seen_o <= seen_o + 1;
        if (m_axis_tuser) degen_o <= degen_o + 1;
        if (expect_q.size() == 0) begin
          $error("unexpected result node %0d", m_axis_tdata[15:0]);
          errs++;
        end else begin
          e = expect_q.pop_front();
          if (e.node !== m_axis_tdata[15:0]) begin
            $error("%s exp %0d got %0d", fname[9], e.node, m_axis_tdata[15:0]);
            errs++;
          end
          for (int i = 0; i < 9; i++)
            if (e.vals[i*48 +: 48] !== m_axis_tdata[16 + i*48 +: 48]) begin
              $error("%s exp %0d got %0d", fname[i], $signed(e.vals[i*48 +: 48]),
                     $signed(m_axis_tdata[16 + i*48 +: 48]));
              errs++;
            end
          if (e.degen !== m_axis_tuser) begin
            $error("degenerate exp %0b got %0b", e.degen, m_axis_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      pending_o <= expect_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for sphere_contact_force_stiffness_unit: drives config and nodes,
// idles both sides in phases, and reports the verdict. Depends on scf_pkg, scf_tb_checker.
`timescale 1ns / 1ps

module tb;
  import scf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int fails, pending, seen, degens;
  int send_idle, recv_idle;

  always #1 clk_i = ~clk_i;

  sphere_contact_force_stiffness_unit DUT (.*);

  scf_tb_checker u_chk (.*, .fail_cnt_o(fails), .pending_o(pending), .seen_o(seen),
                        .degen_o(degens));

  // receiver stalls at random
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_node(input logic [15:0] node, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz,
                           input logic act);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px, node};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  task automatic set_sphere(input logic [31:0] x, y, z, r, kcomp, ktens);
    write_reg(CfgCentreX, x);
    write_reg(CfgCentreY, y);
    write_reg(CfgCentreZ, z);
    write_reg(CfgRadius, r);
    write_reg(CfgStiffComp, kcomp);
    write_reg(CfgStiffTens, ktens);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int mode;
    send_idle = 0; recv_idle = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled block: radius still zero
    send_node(16'd1, 32'h10000, 0, 0, 1'b1);
    drain_pipe();
    set_sphere(0, 0, 0, 32'h10000, 32'h20000, 32'h8000);
    // directed: on centre, inactive, inside, outside, on surface, extremes
    send_node(16'd0, 0, 0, 0, 1'b1);
    send_node(16'd2, 32'h8000, 0, 0, 1'b0);
    send_node(16'd3, 32'h8000, 0, 0, 1'b1);
    send_node(16'd4, 0, 32'h30000, 0, 1'b1);
    send_node(16'd5, 0, 0, 32'h10000, 1'b1);
    send_node(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_node(16'd6, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    send_node(16'd7, 32'h1, 32'hFFFFFFFF, 32'h1, 1'b1);
    send_node(16'd8, 32'h4000, 32'hFFFFC000, 32'h4000, 1'b1);
    drain_pipe();
    set_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF);
    send_node(16'd9, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    send_node(16'd10, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_node(16'd11, 0, 0, 0, 1'b1);
    send_node(16'd12, 32'h7FFFFFFE, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    drain_pipe();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 75) : 0;
      recv_idle = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 24 : 75) : 0;
      case (ph % 3)
        0: set_sphere($urandom, $urandom, $urandom, $urandom_range(1, 32'h7FFFFFFF),
                      $urandom, $urandom);
        1: set_sphere(rand_coord(2), rand_coord(2), rand_coord(2),
                      $urandom_range(1, 8 << 16), $urandom_range(0, 100 << 16),
                      $urandom_range(0, 100 << 16));
        default: set_sphere(0, 0, 0, 1, $urandom_range(1, 3), 32'hFFFFFFFF);
      endcase
      for (int n = 0; n < 180; n++) begin
        mode = (n % 7 == 0) ? 0 : ((ph % 3 == 0) ? 0 : 1 + (n & 1));
        send_node(16'($urandom), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  $urandom_range(99) < 85);
      end
      // hold off until every expected result is back
      drain_pipe();
    end

    $display("covered %0d results (%0d degenerate) over eight sphere settings",
             seen, degens);
    if (fails == 0)
      $display("[sphere_contact_force_stiffness_unit] OK");
    else
      $display("[sphere_contact_force_stiffness_unit] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[sphere_contact_force_stiffness_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/scf_pkg.sv
rtl/scf_div.sv
rtl/sphere_contact_force_stiffness_unit.sv
rtl/scf_checker.sv
test/scf_checker.sv
test/tb.sv
